>>> hdl/tepd_pkg.sv
// tepd_pkg: shared widths, command codes and payload types for the
// task event dispatcher; used by the cell chain and the top level
`timescale 1ns / 1ps
package tepd_pkg;

  localparam int TASK_IDX_W    = 4;
  localparam int EVENT_W       = 16;
  localparam int COUNT_W       = 5;
  localparam int DEF_MAX_TASKS = 16;
  localparam int ADDR_TASKS    = 1 << TASK_IDX_W;

  localparam logic [1:0] CMD_SET  = 2'd0;
  localparam logic [1:0] CMD_CLR  = 2'd1;
  localparam logic [1:0] CMD_DISP = 2'd2;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [TASK_IDX_W-1:0] task_index;
    logic [EVENT_W-1:0]    event_bits;
  } in_item_t;

  typedef struct packed {
    logic                  accepted;
    logic                  ready_found;
    logic [TASK_IDX_W-1:0] chosen_task;
    logic [EVENT_W-1:0]    taken_events;
  } out_item_t;

  // set/clear broadcast to every cell
  typedef struct packed {
    logic                  en;
    logic                  clr;
    logic [TASK_IDX_W-1:0] tix;
    logic [EVENT_W-1:0]    bits;
  } wr_cmd_t;

  // dispatch token walking down the chain
  typedef struct packed {
    logic                  active;
    logic                  found;
    logic [TASK_IDX_W-1:0] idx;
    logic [EVENT_W-1:0]    flags;
  } token_t;

endpackage

>>> hdl/tepd_cell.sv
// tepd_cell: one task's pending event word plus one stage of the dispatch token
// chain; depends on tepd_pkg
`timescale 1ns / 1ps
module tepd_cell
  import tepd_pkg::*;
#(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = COUNT_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] live_cnt,
  input  wr_cmd_t          wr,
  input  token_t           tok_in,
  output token_t           tok_out
);

  localparam bit Addressable = CELL_IDX < ADDR_TASKS;

  logic [EVENT_W-1:0] flags_r, flags_nxt;
  token_t             tok_r, tok_nxt;
  logic               is_live;
  logic               hit;
  logic               claim;

  assign is_live = CNT_W'(CELL_IDX) < live_cnt;
  assign hit     = Addressable && wr.en && (wr.tix == CELL_IDX[TASK_IDX_W-1:0]);
  // first live cell with pending flags takes the token
  assign claim   = tok_in.active && !tok_in.found && is_live && (flags_r != '0);

  always_comb begin
    flags_nxt = flags_r;
    tok_nxt   = tok_in;
    if (hit) begin
      flags_nxt = wr.clr ? (flags_r & ~wr.bits) : (flags_r | wr.bits);
    end else if (claim) begin
      flags_nxt     = '0;
      tok_nxt.found = 1'b1;
      tok_nxt.idx   = CELL_IDX[TASK_IDX_W-1:0];
      tok_nxt.flags = flags_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r      <= '0;
      tok_r.active <= 1'b0;
    end else begin
      flags_r      <= flags_nxt;
      tok_r.active <= tok_nxt.active;
    end
    tok_r.found <= tok_nxt.found;
    tok_r.idx   <= tok_nxt.idx;
    tok_r.flags <= tok_nxt.flags;
  end

  assign tok_out = tok_r;

endmodule

>>> hdl/task_event_priority_dispatcher.sv
// task_event_priority_dispatcher: top level, command decode, token launch and
// output register around a chain of tepd_cell; depends on tepd_pkg, tepd_cell
//
//   channel  direction  ports                          payload
//   in       input      in_valid, in_stall, in_data    in_item_t
//   out      output     out_valid, out_stall, out_data out_item_t
//   cfg      input      cfg_we, cfg_wdata              task_count, 5 bits
//
// set, clear and unused commands write their result straight into the output register
// dispatch: the token steps one cell per clock through all MAX_TASKS cells,
// then into the result hold register, then, once the output is free, into
// the output register
// one command is in progress at a time; a held output stalls the next command
// reset clears every event word and the task count in the same cycle
module task_event_priority_dispatcher
  import tepd_pkg::*;
#(
  parameter int MAX_TASKS = DEF_MAX_TASKS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata
);

  localparam int LiveW = $clog2(MAX_TASKS + 1);
  localparam int CntW  = (LiveW > COUNT_W) ? LiveW : COUNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [COUNT_W-1:0] task_count_r;
  logic [CntW-1:0]    live_cnt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;
  out_item_t          done_r, done_nxt;
  logic               out_free;
  logic               in_acc;
  logic               tix_ok;
  wr_cmd_t            wr;
  token_t             tok_w [MAX_TASKS+1];
  token_t             tok_end;

  assign live_cnt = (CntW'(task_count_r) > CntW'(MAX_TASKS)) ? CntW'(MAX_TASKS)
                                                             : CntW'(task_count_r);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign tix_ok   = CntW'(in_data.task_index) < live_cnt;

  assign wr.en   = in_acc && tix_ok &&
                   (in_data.cmd == CMD_SET || in_data.cmd == CMD_CLR);
  assign wr.clr  = in_data.cmd == CMD_CLR;
  assign wr.tix  = in_data.task_index;
  assign wr.bits = in_data.event_bits;

  assign tok_w[0].active = in_acc && (in_data.cmd == CMD_DISP);
  assign tok_w[0].found  = 1'b0;
  assign tok_w[0].idx    = '0;
  assign tok_w[0].flags  = '0;

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    tepd_cell #(
      .CELL_IDX (g),
      .CNT_W    (CntW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .live_cnt (live_cnt),
      .wr       (wr),
      .tok_in   (tok_w[g]),
      .tok_out  (tok_w[g+1])
    );
  end

  assign tok_end = tok_w[MAX_TASKS];

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    done_nxt      = done_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.cmd == CMD_DISP) begin
            state_nxt = ST_SCAN;
          end else begin
            out_valid_nxt             = 1'b1;
            out_data_nxt              = '0;
            out_data_nxt.accepted     = wr.en;
          end
        end
      end
      ST_SCAN: begin
        if (tok_end.active) begin
          done_nxt.accepted     = tok_end.found;
          done_nxt.ready_found  = tok_end.found;
          done_nxt.chosen_task  = tok_end.found ? tok_end.idx : '0;
          done_nxt.taken_events = tok_end.found ? tok_end.flags : '0;
          state_nxt             = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = done_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      task_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        task_count_r <= cfg_wdata;
      end
    end
    out_data_r <= out_data_nxt;
    done_r     <= done_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_found_is_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.ready_found || out_data_r.accepted))
    else $error("ready_found without accepted");

  a_found_has_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && tok_end.active && tok_end.found) |-> (tok_end.flags != '0))
    else $error("dispatch chose a task with no flags");

  a_disp_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.cmd == CMD_DISP) |=> (state_r == ST_SCAN))
    else $error("dispatch did not start a scan");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input taken while a dispatch is in progress");

  a_token_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok_end.active |-> (state_r == ST_SCAN))
    else $error("token left the chain outside a scan");

endmodule

>>> bench/task_event_priority_dispatcher_test.sv
// task_event_priority_dispatcher_test: self-checking bench for the event flag dispatcher,
// directed and random command streams against an in-bench flag store; needs tepd_pkg and the rtl
`timescale 1ns / 1ps
module task_event_priority_dispatcher_test;
  import tepd_pkg::*;

  localparam int          TASK_SLOTS  = DEF_MAX_TASKS;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int          STALL_LIMIT = 2000;
  localparam int          SEG_ITEMS   = 57;
  localparam int          SHOW_LIMIT  = 10;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_we    = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;

  // bench copy of the flag store and the task count
  logic [EVENT_W-1:0] flag_words [TASK_SLOTS];
  logic [COUNT_W-1:0] task_limit;
  out_item_t          expected_results [$];
  out_item_t          want;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned fail_count    = 0;
  int unsigned quiet_cycles  = 0;

  task_event_priority_dispatcher #(
    .MAX_TASKS(TASK_SLOTS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic in_item_t make_cmd(logic [1:0] cmd, int unsigned idx,
                                        logic [EVENT_W-1:0] bits);
    in_item_t it;
    it.cmd        = cmd;
    it.task_index = idx[TASK_IDX_W-1:0];
    it.event_bits = bits;
    return it;
  endfunction

  // applies one command to the flag store and returns the result it should give
  function automatic out_item_t apply_command(in_item_t it);
    out_item_t   res;
    int unsigned live;
    int unsigned k;
    bit          hit;
    res  = '0;
    hit  = 1'b0;
    live = (task_limit > TASK_SLOTS) ? TASK_SLOTS : task_limit;
    case (it.cmd)
      CMD_SET: begin
        if (it.task_index < live) begin
          flag_words[it.task_index] |= it.event_bits;
          res.accepted = 1'b1;
        end
      end
      CMD_CLR: begin
        if (it.task_index < live) begin
          flag_words[it.task_index] &= ~it.event_bits;
          res.accepted = 1'b1;
        end
      end
      CMD_DISP: begin
        for (k = 0; k < live; k++) begin
          if (!hit && flag_words[k] != '0) begin
            hit              = 1'b1;
            res.accepted     = 1'b1;
            res.ready_found  = 1'b1;
            res.chosen_task  = k[TASK_IDX_W-1:0];
            res.taken_events = flag_words[k];
            flag_words[k]    = '0;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // returns at the edge that accepts the transaction; valid stays up for a follow-on
  task automatic send_command(in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(apply_command(it));
  endtask

  task automatic write_task_count(logic [COUNT_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    task_limit = value;
    cfg_we    <= 1'b0;
  endtask

  function automatic in_item_t random_command();
    in_item_t    it;
    int unsigned live;
    int unsigned pick;
    live = (task_limit > TASK_SLOTS) ? TASK_SLOTS : task_limit;
    pick = $urandom_range(0, 99);
    if (pick < 45)      it.cmd = CMD_SET;
    else if (pick < 65) it.cmd = CMD_CLR;
    else if (pick < 93) it.cmd = CMD_DISP;
    else                it.cmd = CMD_UNUSED;
    // mostly registered tasks, some out-of-range noise
    if (live != 0 && $urandom_range(0, 99) < 85)
      it.task_index = TASK_IDX_W'($urandom_range(0, live - 1));
    else
      it.task_index = TASK_IDX_W'($urandom_range(0, 15));
    pick = $urandom_range(0, 3);
    case (pick)
      0:       it.event_bits = 16'h1 << $urandom_range(0, 15);
      1:       it.event_bits = EVENT_W'($urandom & $urandom);
      default: it.event_bits = EVENT_W'($urandom);
    endcase
    return it;
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
          $display("unexpected result: acc=%0b rdy=%0b task=%0d ev=%h",
                   out_data.accepted, out_data.ready_found,
                   out_data.chosen_task, out_data.taken_events);
      end else begin
        want = expected_results.pop_front();
        if (out_data.accepted !== want.accepted ||
            out_data.ready_found !== want.ready_found ||
            out_data.chosen_task !== want.chosen_task ||
            out_data.taken_events !== want.taken_events) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT)
            $display({"mismatch: expected acc=%0b rdy=%0b task=%0d ev=%h,",
                      " got acc=%0b rdy=%0b task=%0d ev=%h"},
                     want.accepted, want.ready_found, want.chosen_task, want.taken_events,
                     out_data.accepted, out_data.ready_found,
                     out_data.chosen_task, out_data.taken_events);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // task count of zero: nothing is registered
  task automatic test_after_reset();
    send_command(make_cmd(CMD_DISP, 0, 16'h0000));
    send_command(make_cmd(CMD_SET, 0, 16'hFFFF));
    send_command(make_cmd(CMD_CLR, 0, 16'hFFFF));
    send_command(make_cmd(CMD_UNUSED, 0, 16'hFFFF));
  endtask

  task automatic test_set_clear_pick();
    write_task_count(5'd16);
    send_command(make_cmd(CMD_SET, 0, 16'hFFFF));
    send_command(make_cmd(CMD_SET, 15, 16'h8000));
    send_command(make_cmd(CMD_SET, 7, 16'h00A5));
    send_command(make_cmd(CMD_CLR, 0, 16'hFF00));
    send_command(make_cmd(CMD_UNUSED, 15, 16'hFFFF));
    send_command(make_cmd(CMD_DISP, 9, 16'h1234));
    send_command(make_cmd(CMD_DISP, 0, 16'h0000));
    send_command(make_cmd(CMD_DISP, 0, 16'h0000));
    send_command(make_cmd(CMD_DISP, 0, 16'h0000));
    send_command(make_cmd(CMD_CLR, 3, 16'hFFFF));
  endtask

  // count above capacity, then lowered count hiding kept flags
  task automatic test_count_range();
    write_task_count(5'd31);
    send_command(make_cmd(CMD_SET, 15, 16'hFFFF));
    write_task_count(5'd4);
    send_command(make_cmd(CMD_SET, 15, 16'h0001));
    send_command(make_cmd(CMD_CLR, 15, 16'hFFFF));
    send_command(make_cmd(CMD_SET, 3, 16'h0F0F));
    send_command(make_cmd(CMD_DISP, 0, 16'h0000));
    send_command(make_cmd(CMD_DISP, 0, 16'h0000));
    write_task_count(5'd16);
    send_command(make_cmd(CMD_DISP, 0, 16'h0000));
    write_task_count(5'd1);
    send_command(make_cmd(CMD_SET, 0, 16'h0001));
    send_command(make_cmd(CMD_SET, 1, 16'h0001));
    send_command(make_cmd(CMD_DISP, 0, 16'h0000));
  endtask

  task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct);
    int unsigned seg;
    int unsigned n;
    logic [COUNT_W-1:0] count;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (seg = 0; seg < 5; seg++) begin
      case (seg)
        0:       count = 5'd16;
        1:       count = COUNT_W'($urandom_range(1, 15));
        2:       count = COUNT_W'($urandom_range(17, 31));
        3:       count = 5'd1;
        default: count = COUNT_W'($urandom_range(0, 31));
      endcase
      write_task_count(count);
      for (n = 0; n < SEG_ITEMS; n++) send_command(random_command());
    end
  endtask

  initial begin
    for (int k = 0; k < TASK_SLOTS; k++) flag_words[k] = '0;
    task_limit = '0;
    send_idle_pct = 27;
    recv_idle_pct = 49;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_set_clear_pick();
    test_count_range();
    test_random_traffic(27, 49);
    test_random_traffic(49, 27);
    test_random_traffic(0, 0);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TASK_SLOTS + 4) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
